// ===== rtl/mbet_pkg.sv =====
// Shared types and constants for the Mandelbrot escape-time block.
// Used by the multiplier cells, the multiplier chain and the top level.
`timescale 1ns / 1ps
package mbet_pkg;

    // Field formats
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 28;
    localparam int COUNT_WIDTH = 16;
    localparam int LIMIT_WIDTH = 16;
    localparam int BOUND_WIDTH = 32;
    localparam int CFG_WIDTH   = 32;
    localparam int CFG_IDX_WIDTH = 1;

    // Register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ITER_LIMIT = 1'b0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ESC_BOUND  = 1'b1;

    // A non-escaped z stays below 2^MAG_BITS; beyond that its square tops any bound
    localparam int MAG_BITS    = (FRAC_BITS + 34) / 2;
    localparam int MUL_WIDTH   = (FRAC_BITS + 4 > MAG_BITS + 1) ? FRAC_BITS + 4 : MAG_BITS + 1;
    localparam int DIGIT_WIDTH = 8;
    localparam int NUM_CELLS   = (MUL_WIDTH + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
    localparam int MPLR_WIDTH  = NUM_CELLS * DIGIT_WIDTH;
    localparam int PROD_WIDTH  = MUL_WIDTH + MPLR_WIDTH;

    // Point width after sign extension, wide enough for the region gate
    localparam int PT_WIDTH  = (COORD_WIDTH > FRAC_BITS + 3) ? COORD_WIDTH : FRAC_BITS + 3;
    // Width of squares, sums and z
    localparam int SQ_BITS   = 2 * MAG_BITS - FRAC_BITS + 2;
    localparam int SUM_BASE0 = (COORD_WIDTH > SQ_BITS) ? COORD_WIDTH : SQ_BITS;
    localparam int SUM_BASE  = (SUM_BASE0 > FRAC_BITS + 4) ? SUM_BASE0 : FRAC_BITS + 4;
    localparam int SUM_WIDTH = SUM_BASE + 3;
    localparam int EXT_WIDTH = (PROD_WIDTH > SUM_WIDTH) ? PROD_WIDTH : SUM_WIDTH;

    // Fixed-point constants
    localparam logic signed [PT_WIDTH-1:0] PT_GATE_X  = PT_WIDTH'(3) << (FRAC_BITS - 1);
    localparam logic signed [PT_WIDTH-1:0] PT_ONE     = PT_WIDTH'(1) << FRAC_BITS;
    localparam logic signed [PT_WIDTH-1:0] PT_QUARTER = PT_WIDTH'(1) << (FRAC_BITS - 2);
    localparam logic signed [SUM_WIDTH-1:0] SUM_BULB    = SUM_WIDTH'(1) << (FRAC_BITS - 4);
    localparam logic signed [SUM_WIDTH-1:0] SUM_MAG_LIM = SUM_WIDTH'(1) << MAG_BITS;

    // Product tags carried down the multiplier chain
    typedef enum logic [2:0] {
        PROD_A2,
        PROD_Y2,
        PROD_DX2,
        PROD_QQA,
        PROD_ZR2,
        PROD_ZI2,
        PROD_ZRI
    } t_prod;

    typedef struct packed {
        logic  vld;
        t_prod tag;
    } t_mul_ctl;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SC_ISSUE,
        ST_SC_WAIT,
        ST_SC_Q,
        ST_SC_QQA,
        ST_SC_WAIT2,
        ST_SC_DECIDE,
        ST_IT_CHECK,
        ST_IT_ISSUE,
        ST_IT_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_re;
        logic signed [COORD_WIDTH-1:0] point_im;
    } t_in_word;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] iteration_count;
        logic                   inside_res;
        logic                   shortcut;
    } t_out_word;

endpackage

// ===== rtl/mbet_cell.sv =====
// One multiplier cell: adds the product of the multiplicand and one
// multiplier digit into the running sum. Depends on mbet_pkg.
`timescale 1ns / 1ps
module mbet_cell #(
    parameter int CELL_IDX  = 0,
    parameter bit TOP_DIGIT = 1'b0
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  mbet_pkg::t_mul_ctl                         i_ctl,
    input  logic signed [mbet_pkg::MUL_WIDTH-1:0]      i_mcand,
    input  logic signed [mbet_pkg::MPLR_WIDTH-1:0]     i_mplr,
    input  logic signed [mbet_pkg::PROD_WIDTH-1:0]     i_acc,
    output mbet_pkg::t_mul_ctl                         o_ctl,
    output logic signed [mbet_pkg::MUL_WIDTH-1:0]      o_mcand,
    output logic signed [mbet_pkg::MPLR_WIDTH-1:0]     o_mplr,
    output logic signed [mbet_pkg::PROD_WIDTH-1:0]     o_acc
);
    import mbet_pkg::*;

    logic        [DIGIT_WIDTH-1:0]         w_digit;
    logic signed [DIGIT_WIDTH:0]           w_digit_s;
    logic signed [MUL_WIDTH+DIGIT_WIDTH:0] w_pp;
    logic signed [PROD_WIDTH-1:0]          w_term;

    // Pick this cell's digit; only the top digit carries the sign
    assign w_digit   = i_mplr[CELL_IDX*DIGIT_WIDTH +: DIGIT_WIDTH];
    assign w_digit_s = TOP_DIGIT ? {w_digit[DIGIT_WIDTH-1], w_digit} : {1'b0, w_digit};

    // Weight the partial product by the digit position
    assign w_pp   = i_mcand * w_digit_s;
    assign w_term = PROD_WIDTH'(w_pp) <<< (CELL_IDX * DIGIT_WIDTH);

    // Hand the word to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        o_mcand <= i_mcand;
        o_mplr  <= i_mplr;
        o_acc   <= i_acc + w_term;
    end

endmodule

// ===== rtl/mbet_mul_chain.sv =====
// Pipelined signed multiplier built as a row of digit cells.
// Depends on mbet_pkg and mbet_cell.
`timescale 1ns / 1ps
module mbet_mul_chain (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mbet_pkg::t_mul_ctl                     i_ctl,
    input  logic signed [mbet_pkg::MUL_WIDTH-1:0]  i_mcand,
    input  logic signed [mbet_pkg::MUL_WIDTH-1:0]  i_mplr,
    output mbet_pkg::t_mul_ctl                     o_ctl,
    output logic signed [mbet_pkg::PROD_WIDTH-1:0] o_prod
);
    import mbet_pkg::*;

    t_mul_ctl                    s_ctl   [0:NUM_CELLS];
    logic signed [MUL_WIDTH-1:0]  s_mcand [0:NUM_CELLS];
    logic signed [MPLR_WIDTH-1:0] s_mplr  [0:NUM_CELLS];
    logic signed [PROD_WIDTH-1:0] s_acc   [0:NUM_CELLS];

    // Feed the first cell with a cleared sum
    assign s_ctl[0]   = i_ctl;
    assign s_mcand[0] = i_mcand;
    assign s_mplr[0]  = MPLR_WIDTH'(i_mplr);
    assign s_acc[0]   = '0;

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        mbet_cell #(
            .CELL_IDX  (k),
            .TOP_DIGIT (k == NUM_CELLS - 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (s_ctl[k]),
            .i_mcand (s_mcand[k]),
            .i_mplr  (s_mplr[k]),
            .i_acc   (s_acc[k]),
            .o_ctl   (s_ctl[k+1]),
            .o_mcand (s_mcand[k+1]),
            .o_mplr  (s_mplr[k+1]),
            .o_acc   (s_acc[k+1])
        );
    end

    assign o_ctl  = s_ctl[NUM_CELLS];
    assign o_prod = s_acc[NUM_CELLS];

endmodule

// ===== rtl/mandelbrot_escape_time.sv =====
// Mandelbrot escape-time top level: region test, z*z + c iteration, result register.
// Depends on mbet_pkg and mbet_mul_chain.
//
//   channel   valid         stall         data
//   input     i_in_valid    o_in_stall    i_in_data  (point_re, point_im)
//   output    o_out_valid   i_out_stall   o_out_data (iteration_count, inside_res, shortcut)
//   config    i_cfg_we      -             i_cfg_idx, i_cfg_data
//
// All products go through one pipelined multiplier of NUM_CELLS digit cells
// (4 at the default widths). The region test issues three products, waits for
// the chain, forms q and q + a, issues the cardioid product, then decides; each
// iteration issues three products, drains the chain and makes one check.
// One point is worked at a time; the next is taken once the result sits in the
// output register. Reset is synchronous, active low, and restores the registers
// of the control block; the datapath registers are not reset.
`timescale 1ns / 1ps
module mandelbrot_escape_time (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  mbet_pkg::t_in_word                     i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output mbet_pkg::t_out_word                    o_out_data,
    input  logic                                   i_cfg_we,
    input  logic [mbet_pkg::CFG_IDX_WIDTH-1:0]     i_cfg_idx,
    input  logic [mbet_pkg::CFG_WIDTH-1:0]         i_cfg_data
);
    import mbet_pkg::*;

    t_state r_state, n_state;
    logic [1:0] r_sub;
    logic [LIMIT_WIDTH-1:0] r_limit;
    logic [BOUND_WIDTH-1:0] r_bound;
    logic signed [PT_WIDTH-1:0] r_cx, r_cy;
    logic signed [SUM_WIDTH-1:0] r_pa, r_pb, r_pc, r_pd, r_rhs;
    logic signed [SUM_WIDTH-1:0] r_q, r_qa, r_zr, r_zi;
    logic [LIMIT_WIDTH-1:0] r_iter;
    logic r_big, r_sc;
    logic r_out_vld;
    t_out_word r_out;

    t_mul_ctl                    w_mul_ctl, w_res_ctl;
    logic signed [MUL_WIDTH-1:0]  w_mul_a, w_mul_b;
    logic signed [PROD_WIDTH-1:0] w_prod;
    logic signed [EXT_WIDTH-1:0]  w_pe;
    logic signed [SUM_WIDTH-1:0]  w_sh_f, w_sh_f1, w_sh_f2;
    logic signed [PT_WIDTH-1:0]   w_a, w_dx;
    logic signed [SUM_WIDTH-1:0]  w_mag, w_bulb;
    logic w_gate, w_hit, w_go, w_zbig, w_load;
    logic [LIMIT_WIDTH-1:0] w_cnt;

    // Multiplier row
    mbet_mul_chain u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mul_ctl),
        .i_mcand (w_mul_a),
        .i_mplr  (w_mul_b),
        .o_ctl   (w_res_ctl),
        .o_prod  (w_prod)
    );

    // Scale products back to the point format
    assign w_pe    = EXT_WIDTH'(w_prod);
    assign w_sh_f  = SUM_WIDTH'(w_pe >>> FRAC_BITS);
    assign w_sh_f1 = SUM_WIDTH'(w_pe >>> (FRAC_BITS - 1));
    assign w_sh_f2 = SUM_WIDTH'(w_pe >>> (FRAC_BITS + 2));

    // Region gate and test terms
    assign w_gate = (r_cx < PT_GATE_X) && (r_cx > -PT_GATE_X) &&
                    (r_cy < PT_ONE) && (r_cy > -PT_ONE);
    assign w_a    = r_cx - PT_QUARTER;
    assign w_dx   = r_cx + PT_ONE;
    assign w_bulb = r_pc + r_pb;
    assign w_hit  = w_gate && ((r_pd <= r_rhs) || (w_bulb <= SUM_BULB));

    // Loop test: iteration limit, |z|^2 against the bound, and the size flag
    assign w_mag  = r_pa + r_pb;
    assign w_go   = (r_iter < r_limit) && !r_big &&
                    ($unsigned(w_mag) <= SUM_WIDTH'(r_bound));
    assign w_zbig = (r_zr >= SUM_MAG_LIM) || (r_zr <= -SUM_MAG_LIM) ||
                    (r_zi >= SUM_MAG_LIM) || (r_zi <= -SUM_MAG_LIM);

    assign w_load = (r_state == ST_DONE) && (!r_out_vld || !i_out_stall);
    assign w_cnt  = r_sc ? r_limit : r_iter;

    // Next state and multiplier issue
    always_comb begin
        n_state   = r_state;
        w_mul_ctl = '{vld: 1'b0, tag: PROD_A2};
        w_mul_a   = '0;
        w_mul_b   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SC_ISSUE;
            end
            ST_SC_ISSUE: begin
                w_mul_ctl.vld = 1'b1;
                case (r_sub)
                    2'd0: begin
                        w_mul_ctl.tag = PROD_A2;
                        w_mul_a = MUL_WIDTH'(w_a);
                        w_mul_b = MUL_WIDTH'(w_a);
                    end
                    2'd1: begin
                        w_mul_ctl.tag = PROD_Y2;
                        w_mul_a = MUL_WIDTH'(r_cy);
                        w_mul_b = MUL_WIDTH'(r_cy);
                    end
                    default: begin
                        w_mul_ctl.tag = PROD_DX2;
                        w_mul_a = MUL_WIDTH'(w_dx);
                        w_mul_b = MUL_WIDTH'(w_dx);
                        n_state = ST_SC_WAIT;
                    end
                endcase
            end
            ST_SC_WAIT: begin
                if (w_res_ctl.vld && w_res_ctl.tag == PROD_DX2) n_state = ST_SC_Q;
            end
            ST_SC_Q: begin
                n_state = ST_SC_QQA;
            end
            ST_SC_QQA: begin
                w_mul_ctl = '{vld: 1'b1, tag: PROD_QQA};
                w_mul_a   = MUL_WIDTH'(r_q);
                w_mul_b   = MUL_WIDTH'(r_qa);
                n_state   = ST_SC_WAIT2;
            end
            ST_SC_WAIT2: begin
                if (w_res_ctl.vld && w_res_ctl.tag == PROD_QQA) n_state = ST_SC_DECIDE;
            end
            ST_SC_DECIDE: begin
                n_state = w_hit ? ST_DONE : ST_IT_CHECK;
            end
            ST_IT_CHECK: begin
                n_state = w_go ? ST_IT_ISSUE : ST_DONE;
            end
            ST_IT_ISSUE: begin
                w_mul_ctl.vld = 1'b1;
                case (r_sub)
                    2'd0: begin
                        w_mul_ctl.tag = PROD_ZR2;
                        w_mul_a = MUL_WIDTH'(r_zr);
                        w_mul_b = MUL_WIDTH'(r_zr);
                    end
                    2'd1: begin
                        w_mul_ctl.tag = PROD_ZI2;
                        w_mul_a = MUL_WIDTH'(r_zi);
                        w_mul_b = MUL_WIDTH'(r_zi);
                    end
                    default: begin
                        w_mul_ctl.tag = PROD_ZRI;
                        w_mul_a = MUL_WIDTH'(r_zr);
                        w_mul_b = MUL_WIDTH'(r_zi);
                        n_state = ST_IT_WAIT;
                    end
                endcase
            end
            ST_IT_WAIT: begin
                if (w_res_ctl.vld && w_res_ctl.tag == PROD_ZRI) n_state = ST_IT_CHECK;
            end
            ST_DONE: begin
                if (w_load) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sub     <= '0;
            r_out_vld <= 1'b0;
            r_limit   <= LIMIT_WIDTH'(256);
            r_bound   <= BOUND_WIDTH'(1) << (FRAC_BITS + 2);
        end else begin
            r_state <= n_state;
            if ((r_state == ST_SC_ISSUE || r_state == ST_IT_ISSUE) && n_state == r_state) begin
                r_sub <= r_sub + 2'd1;
            end else begin
                r_sub <= '0;
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ITER_LIMIT: r_limit <= i_cfg_data[LIMIT_WIDTH-1:0];
                    CFG_ESC_BOUND:  r_bound <= i_cfg_data[BOUND_WIDTH-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // Take the point
        if (r_state == ST_IDLE && i_in_valid) begin
            r_cx <= PT_WIDTH'(i_in_data.point_re);
            r_cy <= PT_WIDTH'(i_in_data.point_im);
        end

        // Catch products as they leave the row
        if (w_res_ctl.vld) begin
            case (w_res_ctl.tag)
                PROD_A2, PROD_ZR2: r_pa <= w_sh_f;
                PROD_Y2: begin
                    r_pb  <= w_sh_f;
                    r_rhs <= w_sh_f2;
                end
                PROD_ZI2: r_pb <= w_sh_f;
                PROD_DX2: r_pc <= w_sh_f;
                PROD_ZRI: r_pc <= w_sh_f1;
                PROD_QQA: r_pd <= w_sh_f;
                default: ;
            endcase
        end

        // Form q and q + a for the cardioid product
        if (r_state == ST_SC_Q) begin
            r_q  <= w_mag;
            r_qa <= w_mag + SUM_WIDTH'(w_a);
        end

        // Decide the region test; start from z = 0 on a miss
        if (r_state == ST_SC_DECIDE) begin
            r_sc <= w_hit;
            if (!w_hit) begin
                r_pa   <= '0;
                r_pb   <= '0;
                r_pc   <= '0;
                r_iter <= '0;
                r_big  <= 1'b0;
            end
        end

        // Advance z
        if (r_state == ST_IT_CHECK && w_go) begin
            r_zr   <= r_pa - r_pb + SUM_WIDTH'(r_cx);
            r_zi   <= r_pc + SUM_WIDTH'(r_cy);
            r_iter <= r_iter + LIMIT_WIDTH'(1);
        end

        // Flag a z too large to square in range
        if (r_state == ST_IT_ISSUE && r_sub == 2'd0) begin
            r_big <= w_zbig;
        end

        // Load the result word
        if (w_load) begin
            r_out.iteration_count <= COUNT_WIDTH'(w_cnt);
            r_out.inside_res      <= r_sc || (r_iter >= r_limit);
            r_out.shortcut        <= r_sc;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
